### hw/rtl/attack_sustain_decay_envelope_assert.svh
// assertion macros for the envelope generator
`ifndef ATTACK_SUSTAIN_DECAY_ENVELOPE_ASSERT_SVH
`define ATTACK_SUSTAIN_DECAY_ENVELOPE_ASSERT_SVH
`ifndef SYNTH
`define ASDE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`define ASDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASDE_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`define ASDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/asde_pkg.sv
// shared types and constants of the envelope generator
package asde_pkg;

	localparam int LENGTH_BITS    = 20;
	localparam int FRACTION_BITS  = 14;
	localparam int LEVEL_BITS     = FRACTION_BITS + 2;
	localparam int PUNCH_BITS     = FRACTION_BITS + 1;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = (LENGTH_BITS > PUNCH_BITS) ? LENGTH_BITS : PUNCH_BITS;
	localparam int STEP_CNT_BITS  = $clog2(FRACTION_BITS);
	localparam int PROD_BITS      = 2 * PUNCH_BITS;

	localparam logic [LEVEL_BITS-1:0] ONE_LEVEL = LEVEL_BITS'(1) << FRACTION_BITS;
	localparam logic [PUNCH_BITS-1:0] ONE_FRAC  = PUNCH_BITS'(1) << FRACTION_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ATTACK_LENGTH,
		REG_SUSTAIN_LENGTH,
		REG_DECAY_LENGTH,
		REG_PUNCH,
		REG_ONE_SHOT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STG_ATTACK,
		STG_SUSTAIN,
		STG_DECAY,
		STG_DONE
	} stage_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SETUP,
		CS_DIVIDE,
		CS_MULT,
		CS_WRITE
	} ctrl_state_t;

	typedef struct packed {
		logic restart;
		logic note_off;
	} tick_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic                  active;
		stage_t                stage;
	} result_t;

	typedef struct packed {
		logic accept;
		logic setup;
		logic divide;
		logic mult;
		logic write;
	} asde_cmd_t;

	typedef struct packed {
		logic div_done;
	} asde_status_t;

endpackage

### hw/rtl/attack_sustain_decay_envelope.sv
// top level of the attack / sustain / decay envelope generator
// usage:
//   tick channel: one beat per output-sample tick, carrying restart and note_off.
//   result channel: one beat per tick with level (Q2.14), active and stage.
//   config port: cfg_we with cfg_index 0 attack_length, 1 sustain_length,
//   2 decay_length, 3 punch, 4 one_shot; write only while no tick is in flight.
// sequence:
//   a tick beat is taken in idle, then the setup state, a restoring divider
//   for stage progress that runs one quotient bit per cycle (ending early when
//   the progress is 0 or full), the punch multiply state and the write state,
//   which loads the result register; no new tick is taken until the voice is
//   back in idle.
// reset:
//   config and envelope state clear (not the result or most divider regs);
//   the voice is idle (level 0, stage 3) until a tick with restart.
// stall:
//   the result register holds its beat while result_stall is high; the next
//   tick is still taken and its result waits in the write cycle until the
//   result register frees.
module attack_sustain_decay_envelope
	import asde_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick_valid,
	output logic                      tick_stall,
	input  tick_t                     tick,
	output logic                      result_valid,
	input  logic                      result_stall,
	output result_t                   result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	asde_cmd_t    cmd;
	asde_status_t status;

	asde_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	asde_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.tick      (tick),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

### hw/rtl/asde_ctrl.sv
// controller state machine of the envelope generator
`include "attack_sustain_decay_envelope_assert.svh"
module asde_ctrl
	import asde_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         tick_valid,
	output logic         tick_stall,
	output logic         result_valid,
	input  logic         result_stall,
	input  asde_status_t status,
	output asde_cmd_t    cmd
);

	ctrl_state_t              state_q;
	ctrl_state_t              state_next;
	logic [STEP_CNT_BITS-1:0] cnt_q;
	logic                     result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= CS_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.setup) begin
				cnt_q <= '0;
			end else if (cmd.divide) begin
				cnt_q <= cnt_q + STEP_CNT_BITS'(1);
			end
			if (cmd.write) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		tick_stall = 1'b1;
		unique case (state_q)
			CS_IDLE: begin
				tick_stall = 1'b0;
				if (tick_valid) begin
					cmd.accept = 1'b1;
					state_next = CS_SETUP;
				end
			end
			CS_SETUP: begin
				cmd.setup  = 1'b1;
				state_next = CS_DIVIDE;
			end
			CS_DIVIDE: begin
				cmd.divide = 1'b1;
				if (status.div_done || cnt_q == STEP_CNT_BITS'(FRACTION_BITS - 1)) begin
					state_next = CS_MULT;
				end
			end
			CS_MULT: begin
				cmd.mult   = 1'b1;
				state_next = CS_WRITE;
			end
			CS_WRITE: begin
				if (!result_valid_q || !result_stall) begin
					cmd.write  = 1'b1;
					state_next = CS_IDLE;
				end
			end
			default: begin
				state_next = CS_IDLE;
			end
		endcase
	end

	assign result_valid = result_valid_q;

	`ASDE_ASSERT_IMPLIES(a_valid_from_write, clk, arst_n, $rose(result_valid_q), $past(state_q == CS_WRITE), "result beat raised outside write state")
	`ASDE_ASSERT_IMPLIES(a_step_count_bound, clk, arst_n, state_q == CS_DIVIDE, {1'b0, cnt_q} < (STEP_CNT_BITS + 1)'(FRACTION_BITS), "divide step count overran")

endmodule

### hw/rtl/asde_dp.sv
// datapath of the envelope generator: state, serial divider, punch multiplier
`include "attack_sustain_decay_envelope_assert.svh"
module asde_dp
	import asde_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  asde_cmd_t                 cmd,
	output asde_status_t              status,
	input  tick_t                     tick,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output result_t                   result
);

	logic [LENGTH_BITS-1:0] attack_len_q;
	logic [LENGTH_BITS-1:0] sustain_len_q;
	logic [LENGTH_BITS-1:0] decay_len_q;
	logic [PUNCH_BITS-1:0]  punch_q;
	logic                   one_shot_q;

	stage_t                 stage_q;
	logic [LENGTH_BITS-1:0] time_q;
	logic                   released_q;
	logic                   playing_q;
	logic [LEVEL_BITS-1:0]  held_q;

	logic                   idle_q;
	logic                   hold_mode_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [LENGTH_BITS-1:0] den_q;
	logic [PUNCH_BITS-1:0]  quo_q;
	logic                   div_done_q;
	logic [PROD_BITS-1:0]   prod_q;
	result_t                result_q;

	stage_t                 st0;
	logic [LENGTH_BITS-1:0] tm0;
	logic                   rel0;
	logic                   play0;
	logic                   hold0;
	logic [LENGTH_BITS:0]   t1;
	logic [LENGTH_BITS-1:0] len0;
	stage_t                 st_new;
	logic [LENGTH_BITS-1:0] tm_new;
	logic                   play_new;
	logic [LENGTH_BITS-1:0] len_cur;
	logic [LENGTH_BITS:0]   rem2;
	logic [PUNCH_BITS-1:0]  frac;
	logic [PUNCH_BITS-1:0]  punch_sat;
	logic [LEVEL_BITS-1:0]  lvl;

	function automatic logic [LENGTH_BITS-1:0] stage_len(input stage_t s,
			input logic [LENGTH_BITS-1:0] a, input logic [LENGTH_BITS-1:0] b,
			input logic [LENGTH_BITS-1:0] c);
		logic [LENGTH_BITS-1:0] r;
		case (s)
			STG_ATTACK:  r = a;
			STG_SUSTAIN: r = b;
			default:     r = c;
		endcase
		return r;
	endfunction

	// tick update
	always_comb begin
		st0   = tick.restart ? STG_ATTACK : stage_q;
		tm0   = tick.restart ? '0 : time_q;
		rel0  = (!tick.restart && released_q) || (tick.note_off && !one_shot_q);
		play0 = tick.restart || playing_q;
		hold0 = !one_shot_q && !rel0;
		t1    = {1'b0, tm0} + (LENGTH_BITS + 1)'(1);
		len0  = stage_len(st0, attack_len_q, sustain_len_q, decay_len_q);
		st_new   = st0;
		tm_new   = t1[LENGTH_BITS-1:0];
		play_new = play0;
		if (hold0 && st0 == STG_SUSTAIN) begin
			if (t1 > {1'b0, sustain_len_q}) begin
				tm_new = sustain_len_q;
			end
		end else if (st0 == STG_DONE || t1 > {1'b0, len0}) begin
			tm_new   = '0;
			st_new   = (st0 == STG_DONE) ? STG_DONE : stage_t'(st0 + 2'd1);
			play_new = (st_new != STG_DONE);
		end
	end

	assign len_cur   = stage_len(stage_q, attack_len_q, sustain_len_q, decay_len_q);
	assign rem2      = {rem_q, 1'b0};
	assign frac      = ONE_FRAC - quo_q;
	assign punch_sat = (punch_q > ONE_FRAC) ? ONE_FRAC : punch_q;

	always_comb begin
		case (stage_q)
			STG_ATTACK:  lvl = LEVEL_BITS'(quo_q);
			STG_SUSTAIN: lvl = hold_mode_q ? ONE_LEVEL :
				ONE_LEVEL + LEVEL_BITS'(prod_q >> (FRACTION_BITS - 1));
			STG_DECAY:   lvl = ONE_LEVEL - LEVEL_BITS'(quo_q);
			default:     lvl = held_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q  <= '0;
			sustain_len_q <= '0;
			decay_len_q   <= '0;
			punch_q       <= '0;
			one_shot_q    <= 1'b0;
			stage_q       <= STG_ATTACK;
			time_q        <= '0;
			released_q    <= 1'b0;
			playing_q     <= 1'b0;
			held_q        <= '0;
			div_done_q    <= 1'b1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_ATTACK_LENGTH:  attack_len_q  <= cfg_data[LENGTH_BITS-1:0];
					REG_SUSTAIN_LENGTH: sustain_len_q <= cfg_data[LENGTH_BITS-1:0];
					REG_DECAY_LENGTH:   decay_len_q   <= cfg_data[LENGTH_BITS-1:0];
					REG_PUNCH:          punch_q       <= cfg_data[PUNCH_BITS-1:0];
					REG_ONE_SHOT:       one_shot_q    <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				released_q <= rel0;
				if (tick.restart) begin
					held_q <= '0;
				end
				if (play0) begin
					stage_q   <= st_new;
					time_q    <= tm_new;
					playing_q <= play_new;
				end
			end
			if (cmd.setup) begin
				if (len_cur == '0) begin
					div_done_q <= 1'b1;
				end else if (time_q >= len_cur) begin
					div_done_q <= 1'b1;
				end else begin
					div_done_q <= 1'b0;
				end
			end
			if (cmd.write && !idle_q) begin
				held_q <= lvl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idle_q      <= !play0;
			hold_mode_q <= hold0;
		end
		if (cmd.setup) begin
			den_q <= len_cur;
			rem_q <= time_q;
			if (len_cur != '0 && time_q >= len_cur) begin
				quo_q <= ONE_FRAC;
			end else begin
				quo_q <= '0;
			end
		end else if (cmd.divide && !div_done_q) begin
			if (rem2 >= {1'b0, den_q}) begin
				rem_q <= LENGTH_BITS'(rem2 - {1'b0, den_q});
				quo_q <= {quo_q[PUNCH_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem2[LENGTH_BITS-1:0];
				quo_q <= {quo_q[PUNCH_BITS-2:0], 1'b0};
			end
		end
		if (cmd.mult) begin
			prod_q <= PROD_BITS'(frac) * PROD_BITS'(punch_sat);
		end
		if (cmd.write) begin
			if (idle_q) begin
				result_q.level  <= '0;
				result_q.active <= 1'b0;
				result_q.stage  <= STG_DONE;
			end else begin
				result_q.level  <= lvl;
				result_q.active <= playing_q;
				result_q.stage  <= stage_q;
			end
		end
	end

	assign status.div_done = div_done_q;
	assign result          = result_q;

	`ASDE_ASSERT_NEVER(a_playing_not_done, clk, arst_n, playing_q && stage_q == STG_DONE, "playing voice in finished stage")
	`ASDE_ASSERT_NEVER(a_rem_below_den, clk, arst_n, !div_done_q && rem_q >= den_q, "divider remainder not below divisor")
	`ASDE_ASSERT_IMPLIES(a_quo_bound, clk, arst_n, $past(cmd.setup), quo_q <= ONE_FRAC, "progress above one")

endmodule

### tb/sv/asde_envelope_checker.sv
`timescale 1ns / 100ps
// envelope checker: predicts the result of each tick beat and compares result beats
module asde_envelope_checker
	import asde_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick_valid,
	input  logic                      tick_stall,
	input  tick_t                     tick,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  result_t                   result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        mismatches,
	output int                        outstanding
);

	logic [LENGTH_BITS-1:0] attack_len;
	logic [LENGTH_BITS-1:0] sustain_len;
	logic [LENGTH_BITS-1:0] decay_len;
	logic [PUNCH_BITS-1:0]  punch_amt;
	logic                   one_shot_on;

	stage_t                 voice_stage;
	logic [LENGTH_BITS-1:0] voice_ticks;
	logic                   released;
	logic                   playing;
	logic [LEVEL_BITS-1:0]  last_level;

	result_t levels_due[$];

	function automatic logic [LEVEL_BITS-1:0] ramp_fraction(input logic [LENGTH_BITS-1:0] t,
			input logic [LENGTH_BITS-1:0] len);
		logic [63:0] q;
		if (len == '0) begin
			return '0;
		end
		q = (64'(t) << FRACTION_BITS) / 64'(len);
		return (q > 64'(ONE_LEVEL)) ? ONE_LEVEL : q[LEVEL_BITS-1:0];
	endfunction

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic predict_tick(input tick_t t, output result_t r);
		logic                   held;
		logic [LENGTH_BITS:0]   next_time;
		logic [LENGTH_BITS-1:0] len;
		logic [PUNCH_BITS-1:0]  pc;
		logic [63:0]            rem;
		if (t.restart) begin
			voice_stage = STG_ATTACK;
			voice_ticks = '0;
			released    = 1'b0;
			playing     = 1'b1;
			last_level  = '0;
		end
		if (t.note_off && !one_shot_on) begin
			released = 1'b1;
		end
		if (!playing) begin
			r.level  = '0;
			r.active = 1'b0;
			r.stage  = STG_DONE;
			return;
		end
		held = !one_shot_on && !released;
		len = (voice_stage == STG_ATTACK) ? attack_len :
			(voice_stage == STG_SUSTAIN) ? sustain_len : decay_len;
		next_time = {1'b0, voice_ticks} + 1'b1;
		if (held && voice_stage == STG_SUSTAIN) begin
			if (next_time > {1'b0, sustain_len}) begin
				next_time = {1'b0, sustain_len};
			end
		end else if (voice_stage == STG_DONE || next_time > {1'b0, len}) begin
			next_time = '0;
			if (voice_stage != STG_DONE) begin
				voice_stage = stage_t'(voice_stage + 2'd1);
			end
			if (voice_stage == STG_DONE) begin
				playing = 1'b0;
			end
		end
		voice_ticks = next_time[LENGTH_BITS-1:0];
		case (voice_stage)
			STG_ATTACK: begin
				last_level = ramp_fraction(voice_ticks, attack_len);
			end
			STG_SUSTAIN: begin
				if (held) begin
					last_level = ONE_LEVEL;
				end else begin
					pc = (punch_amt > ONE_FRAC) ? ONE_FRAC : punch_amt;
					rem = 64'(ONE_LEVEL) - 64'(ramp_fraction(voice_ticks, sustain_len));
					last_level = ONE_LEVEL + LEVEL_BITS'((rem * 2 * 64'(pc)) >> FRACTION_BITS);
				end
			end
			STG_DECAY: begin
				last_level = ONE_LEVEL - ramp_fraction(voice_ticks, decay_len);
			end
			default: begin
			end
		endcase
		r.level  = last_level;
		r.active = playing;
		r.stage  = voice_stage;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			attack_len  = '0;
			sustain_len = '0;
			decay_len   = '0;
			punch_amt   = '0;
			one_shot_on = 1'b0;
			voice_stage = STG_ATTACK;
			voice_ticks = '0;
			released    = 1'b0;
			playing     = 1'b0;
			last_level  = '0;
			levels_due.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (levels_due.size() == 0) begin
					report($sformatf("result beat with nothing pending: level %0d active %0d stage %0d",
						result.level, result.active, result.stage));
				end else begin
					want = levels_due.pop_front();
					if (result.level !== want.level) begin
						report($sformatf("level %0d, predicted %0d", result.level, want.level));
					end
					if (result.active !== want.active) begin
						report($sformatf("active %0d, predicted %0d", result.active, want.active));
					end
					if (result.stage !== want.stage) begin
						report($sformatf("stage %0d, predicted %0d", result.stage, want.stage));
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ATTACK_LENGTH:  attack_len  = cfg_data[LENGTH_BITS-1:0];
					REG_SUSTAIN_LENGTH: sustain_len = cfg_data[LENGTH_BITS-1:0];
					REG_DECAY_LENGTH:   decay_len   = cfg_data[LENGTH_BITS-1:0];
					REG_PUNCH:          punch_amt   = cfg_data[PUNCH_BITS-1:0];
					REG_ONE_SHOT:       one_shot_on = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (tick_valid && !tick_stall) begin
				predict_tick(tick, want);
				levels_due.push_back(want);
			end
			outstanding = levels_due.size();
		end
	end

endmodule

### tb/sv/tb_attack_sustain_decay_envelope.sv
`timescale 1ns / 100ps
// testbench top: drives ticks, register writes and result stalls into the envelope generator
module tb_attack_sustain_decay_envelope;
	import asde_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 24;
	localparam int PHASE_ITEMS   = 50;
	localparam int RANDOM_PHASES = 8;

	logic                      clk;
	logic                      arst_n;
	logic                      tick_valid;
	logic                      tick_stall;
	tick_t                     tick;
	logic                      result_valid;
	logic                      result_stall;
	result_t                   result;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	int mismatches;
	int outstanding;
	int cycle_count;
	int sender_idle_pct;
	int stall_pct;

	attack_sustain_decay_envelope dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	asde_envelope_checker envelope_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_envelope(input logic [LENGTH_BITS-1:0] a, input logic [LENGTH_BITS-1:0] s,
			input logic [LENGTH_BITS-1:0] d, input logic [PUNCH_BITS-1:0] p, input logic os);
		write_reg(REG_ATTACK_LENGTH, CFG_DATA_BITS'(a));
		write_reg(REG_SUSTAIN_LENGTH, CFG_DATA_BITS'(s));
		write_reg(REG_DECAY_LENGTH, CFG_DATA_BITS'(d));
		write_reg(REG_PUNCH, CFG_DATA_BITS'(p));
		write_reg(REG_ONE_SHOT, CFG_DATA_BITS'(os));
	endtask

	task automatic send_tick(input logic restart, input logic note_off);
		logic taken;
		while ($urandom_range(99) < sender_idle_pct) begin
			tick_valid = 1'b0;
			@(negedge clk);
		end
		tick_valid    = 1'b1;
		tick.restart  = restart;
		tick.note_off = note_off;
		do begin
			@(posedge clk);
			taken = !tick_stall;
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		tick_valid = 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [LENGTH_BITS-1:0] pick_length();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return LENGTH_BITS'($urandom);
			default: return LENGTH_BITS'($urandom_range(12, 1));
		endcase
	endfunction

	initial begin
		int mode;
		logic [PUNCH_BITS-1:0] p;
		arst_n          = 1'b0;
		tick_valid      = 1'b0;
		tick            = '0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		sender_idle_pct = 0;
		stall_pct       = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// idle voice, held note, release with punch, restart carrying a note-off
		load_envelope(LENGTH_BITS'(3), LENGTH_BITS'(4), LENGTH_BITS'(2), PUNCH_BITS'(8192),
			1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		repeat (5) send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		repeat (8) send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		repeat (3) send_tick(1'b0, 1'b0);
		drain();

		// zero-length stages, punch above full scale, one-shot ignores note-off
		load_envelope('0, '0, '0, 15'h7FFF, 1'b1);
		send_tick(1'b1, 1'b1);
		repeat (3) send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			mode = ph % 4;
			if (ph == 1) begin
				load_envelope('1, '1, '1, ONE_FRAC, 1'b0);
			end else if (ph == 2) begin
				load_envelope('0, '0, '0, '1, 1'b1);
			end else begin
				p = ($urandom_range(5) == 0) ? PUNCH_BITS'($urandom) :
					PUNCH_BITS'($urandom_range(16384));
				load_envelope(pick_length(), pick_length(), pick_length(), p,
					1'($urandom_range(1)));
			end
			sender_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 85 : 27) : 0;
			stall_pct       = (mode == 2 || mode == 3) ? ((mode == 2) ? 85 : 27) : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((ph == 0 && n == 20) || $urandom_range(49) == 0) begin
					drain();
				end
				send_tick($urandom_range(99) < 6, $urandom_range(99) < 10);
			end
			drain();
			sender_idle_pct = 0;
			stall_pct       = 0;
		end

		drain();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
